### sv/utf8d_pkg.sv
// shared types, constants and helper functions for the utf-8 decoder
// no dependencies

package utf8d_pkg;

    localparam int MAX_TOKENS      = 4;
    localparam int PEND_DEPTH      = 3;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int VALUE_W         = 21;

    typedef enum logic [1:0] {
        KIND_ASCII   = 2'd0,
        KIND_CODE    = 2'd1,
        KIND_INVALID = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        kind_t               token_kind;
        logic [VALUE_W-1:0]  token_value;
        logic                last_of_run;
    } out_t;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
    } token_t;

    typedef struct packed {
        logic [2:0]                   count;
        token_t [MAX_TOKENS-1:0]      tok;
    } job_t;

    typedef struct packed {
        logic [1:0] count;
        logic [2:0] length;
    } front_stat_t;

    // sequence length opened by a lead byte, zero when not a valid lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= 8'hC2 && b <= 8'hDF)
        begin
            len = 3'd2;
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            len = 3'd3;
        end
        else if (b >= 8'hF0 && b <= 8'hF4)
        begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic cont_ok(input logic [7:0] b);
        return (b >= 8'h80) && (b <= 8'hBF);
    endfunction

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (lead == 8'hE0)
        begin
            lo = 8'hA0;
        end
        else if (lead == 8'hED)
        begin
            hi = 8'h9F;
        end
        else if (lead == 8'hF0)
        begin
            lo = 8'h90;
        end
        else if (lead == 8'hF4)
        begin
            hi = 8'h8F;
        end
        return (b >= lo) && (b <= hi);
    endfunction

endpackage

### sv/utf8d_front.sv
// front end: holds the open sequence, checks each byte and builds its token job
// depends on utf8d_pkg

module utf8d_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  utf8d_pkg::in_t            data,
    input  logic                      take,
    output utf8d_pkg::job_t           job,
    output logic                      job_valid,
    output utf8d_pkg::front_stat_t    stat
);
    import utf8d_pkg::*;

    logic [7:0]         pend_reg [PEND_DEPTH];
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic [2:0]         len_reg;
    logic [2:0]         len_next;

    logic [7:0]         b;
    logic               last;
    logic [2:0]         new_len;
    logic               is_open;
    logic               ok;
    logic [1:0]         base;
    logic               extra_live;
    token_t             extra;
    logic               opening;
    logic               store;
    logic [VALUE_W-1:0] cp;

    assign b       = data.byte_value;
    assign last    = data.end_of_text;
    assign new_len = lead_len(b);
    assign is_open = (len_reg != 3'd0) && (cnt_reg != 2'd0);

    always_comb
    begin
        if (cnt_reg == 2'd1)
        begin
            ok = second_ok(pend_reg[0], b);
        end
        else
        begin
            ok = cont_ok(b);
        end
    end

    always_comb
    begin
        case (len_reg)
            3'd2:    cp = {10'd0, pend_reg[0][4:0], b[5:0]};
            3'd3:    cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], b[5:0]};
            default: cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0], b[5:0]};
        endcase
    end

    always_comb
    begin
        base       = 2'd0;
        extra_live = 1'b0;
        extra      = '{kind: KIND_INVALID, value: {13'd0, b}};
        opening    = 1'b0;
        store      = 1'b0;
        cnt_next   = 2'd0;
        len_next   = 3'd0;
        if (is_open && ok)
        begin
            if (({1'b0, cnt_reg} + 3'd1) < len_reg)
            begin
                if (last)
                begin
                    // cut off: held bytes and this one all flagged
                    base       = cnt_reg;
                    extra_live = 1'b1;
                end
                else
                begin
                    store    = 1'b1;
                    cnt_next = cnt_reg + 2'd1;
                    len_next = len_reg;
                end
            end
            else
            begin
                extra_live = 1'b1;
                extra      = '{kind: KIND_CODE, value: cp};
            end
        end
        else
        begin
            base = is_open ? cnt_reg : 2'd0;
            if (!b[7])
            begin
                extra_live = 1'b1;
                extra      = '{kind: KIND_ASCII, value: {13'd0, b}};
            end
            else if (new_len == 3'd0)
            begin
                extra_live = 1'b1;
            end
            else if (last)
            begin
                extra_live = 1'b1;
            end
            else
            begin
                opening  = 1'b1;
                cnt_next = 2'd1;
                len_next = new_len;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < PEND_DEPTH; i++)
        begin
            if (2'(i) < base)
            begin
                job.tok[i] = '{kind: KIND_INVALID, value: {13'd0, pend_reg[i]}};
            end
            else
            begin
                job.tok[i] = extra;
            end
        end
        job.tok[MAX_TOKENS-1] = extra;
        job.count = {1'b0, base} + {2'd0, extra_live};
    end

    assign job_valid   = take && (job.count != 3'd0);
    assign stat.count  = cnt_reg;
    assign stat.length = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            len_reg <= 3'd0;
        end
        else if (take)
        begin
            cnt_reg <= cnt_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && opening)
        begin
            pend_reg[0] <= b;
        end
        else if (take && store)
        begin
            pend_reg[cnt_reg] <= b;
        end
    end

endmodule

### sv/utf8d_queue.sv
// short job queue between the front and back ends
// depends on utf8d_pkg

module utf8d_queue #(
    parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  utf8d_pkg::job_t  wdata,
    input  logic             pop,
    output utf8d_pkg::job_t  rdata,
    output logic             nonempty,
    output logic             full
);
    import utf8d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;

    assign nonempty = (cnt_reg != CW'(0));
    assign full     = (cnt_reg == CW'(DEPTH));
    assign rdata    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/utf8d_back.sv
// back end: walks the tokens of the head job into the output register
// depends on utf8d_pkg

module utf8d_back (
    input  logic             clk,
    input  logic             rst_n,
    input  utf8d_pkg::job_t  job,
    input  logic             job_valid,
    output logic             job_done,
    output logic             valid,
    input  logic             ready,
    output utf8d_pkg::out_t  data
);
    import utf8d_pkg::*;

    localparam int IW = $clog2(MAX_TOKENS);

    logic [IW-1:0]  idx_reg;
    logic [IW-1:0]  idx_next;
    logic           valid_reg;
    logic           valid_next;
    out_t           data_reg;
    token_t         cur;
    logic           cur_last;
    logic           load;

    assign cur      = job.tok[idx_reg];
    assign cur_last = (3'(idx_reg) + 3'd1) == job.count;
    assign load     = job_valid && (!valid_reg || ready);
    assign job_done = load && cur_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = cur_last ? '0 : idx_reg + IW'(1);
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= '{token_kind: cur.kind, token_value: cur.value, last_of_run: cur_last};
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

### sv/utf8_decode_with_escape_core.sv
// top level of the strict streaming utf-8 decoder
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back

// Takes one byte per cycle whenever the job queue has room and gives one token per cycle
// from a registered output while token_ready is high. A byte that finishes, breaks or cuts
// off a sequence produces one to four tokens, which leave one after another; a byte that
// only opens or extends a sequence produces none. The first token of a byte is written into
// the job queue at the byte's transfer and from there into the output register. The output
// port's one-token-per-cycle drain sets the rate: byte_ready stays high at one byte per
// cycle while bytes average at most one token, and the queue of QUEUE_DEPTH byte jobs
// absorbs the bursts of a broken sequence.
module utf8_decode_with_escape_core #(
    parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_ready,
    input  utf8d_pkg::in_t   byte_data,
    output logic             token_valid,
    input  logic             token_ready,
    output utf8d_pkg::out_t  token_data
);
    import utf8d_pkg::*;

    job_t         front_job;
    logic         q_push;
    job_t         q_head;
    logic         q_nonempty;
    logic         q_full;
    logic         q_pop;
    logic         take;
    front_stat_t  stat;

    assign byte_ready = !q_full;
    assign take       = byte_valid && byte_ready;

    utf8d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .data      (byte_data),
        .take      (take),
        .job       (front_job),
        .job_valid (q_push),
        .stat      (stat)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (front_job),
        .pop      (q_pop),
        .rdata    (q_head),
        .nonempty (q_nonempty),
        .full     (q_full)
    );

    utf8d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_head),
        .job_valid (q_nonempty),
        .job_done  (q_pop),
        .valid     (token_valid),
        .ready     (token_ready),
        .data      (token_data)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("job pushed into full queue");

    a_held_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.count != 2'd0) |-> (stat.length > {1'b0, stat.count}))
        else $error("held byte count not below sequence length");

    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.length != 3'd0) |-> (stat.count != 2'd0))
        else $error("sequence open with no held bytes");

    a_good_token_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && (token_data.token_kind == KIND_ASCII
            || token_data.token_kind == KIND_CODE)) |-> token_data.last_of_run)
        else $error("ascii or code point token not last of its run");

endmodule

### test/tb.sv
// testbench for utf8_decode_with_escape_core: directed and random byte streams
// with random idling on both channels, tokens checked against an in-bench decoder
// depends on utf8d_pkg and the decoder rtl

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8d_pkg::*;

    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;
    localparam int RANDOM_BYTES = 400;
    localparam int DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_ready;
    in_t byte_data = '0;
    logic token_valid;
    logic token_ready = 1'b0;
    out_t token_data;

    in_t byte_queue [$];
    out_t token_expect_q [$];
    int errors = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int calm_left [0:1] = '{0, 0};

    // decoder state as seen from the bench
    logic [7:0] held_bytes [0:2];
    int held_count = 0;
    int seq_length = 0;
    out_t tok_buf [0:3];
    int tok_n;

    utf8_decode_with_escape_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_data(byte_data),
        .token_valid(token_valid),
        .token_ready(token_ready),
        .token_data(token_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int next_gap(input int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_token(input kind_t kind, input logic [20:0] value);
        if (tok_n < MAX_TOKENS)
        begin
            tok_buf[tok_n].token_kind = kind;
            tok_buf[tok_n].token_value = value;
            tok_buf[tok_n].last_of_run = 1'b0;
            tok_n++;
        end
    endfunction

    function automatic void flush_held();
        for (int k = 0; k < held_count; k++)
            add_token(KIND_INVALID, {13'd0, held_bytes[k]});
        held_count = 0;
        seq_length = 0;
    endfunction

    function automatic void start_fresh(input logic [7:0] b);
        int len;
        len = 0;
        if (b <= 8'h7F)
        begin
            add_token(KIND_ASCII, {13'd0, b});
            return;
        end
        if (b >= 8'hC2 && b <= 8'hDF)
            len = 2;
        else if (b >= 8'hE0 && b <= 8'hEF)
            len = 3;
        else if (b >= 8'hF0 && b <= 8'hF4)
            len = 4;
        if (len == 0)
        begin
            add_token(KIND_INVALID, {13'd0, b});
            return;
        end
        held_bytes[0] = b;
        held_count = 1;
        seq_length = len;
    endfunction

    function automatic void decode_byte(input in_t item);
        logic [7:0] b;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [20:0] cp;
        b = item.byte_value;
        tok_n = 0;
        if (seq_length == 0)
        begin
            start_fresh(b);
        end
        else
        begin
            lo = 8'h80;
            hi = 8'hBF;
            // tighter second-byte window against overlongs, surrogates and values past the top
            if (held_count == 1)
            begin
                case (held_bytes[0])
                    8'hE0: lo = 8'hA0;
                    8'hED: hi = 8'h9F;
                    8'hF0: lo = 8'h90;
                    8'hF4: hi = 8'h8F;
                    default: ;
                endcase
            end
            if (b < lo || b > hi)
            begin
                flush_held();
                start_fresh(b);
            end
            else if (held_count + 1 < seq_length)
            begin
                held_bytes[held_count] = b;
                held_count++;
            end
            else
            begin
                case (seq_length)
                    2: cp = {10'd0, held_bytes[0][4:0], b[5:0]};
                    3: cp = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], b[5:0]};
                    default: cp = {held_bytes[0][2:0], held_bytes[1][5:0],
                                   held_bytes[2][5:0], b[5:0]};
                endcase
                held_count = 0;
                seq_length = 0;
                add_token(KIND_CODE, cp);
            end
        end
        if (item.end_of_text && seq_length != 0)
            flush_held();
        if (tok_n > 0)
            tok_buf[tok_n - 1].last_of_run = 1'b1;
        for (int k = 0; k < tok_n; k++)
            token_expect_q = {token_expect_q, tok_buf[k]};
    endfunction

    task automatic queue_byte(input logic [7:0] b, input bit eot);
        in_t item;
        item.byte_value = b;
        item.end_of_text = eot;
        byte_queue = {byte_queue, item};
    endtask

    // encode a code point, optionally keeping only a leading part of it
    task automatic queue_char(input logic [20:0] cp, input int keep, input bit eot);
        logic [7:0] enc [0:3];
        int len;
        if (cp < 21'h80)
        begin
            len = 1;
            enc[0] = cp[7:0];
        end
        else if (cp < 21'h800)
        begin
            len = 2;
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            len = 3;
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            len = 4;
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
        end
        if (keep > 0)
            len = (keep < len) ? keep : len - 1;
        for (int i = 0; i < len; i++)
            queue_byte(enc[i], eot && (i == len - 1));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data <= '0;
            send_gap = 0;
        end
        else
        begin
            if (byte_valid && byte_ready)
                decode_byte(byte_data);
            if (!byte_valid || byte_ready)
            begin
                if (send_gap > 0 || byte_queue.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    byte_valid <= 1'b0;
                end
                else
                begin
                    byte_data <= byte_queue.pop_front();
                    byte_valid <= 1'b1;
                    send_gap = next_gap(SIDE_SEND);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : observe
        out_t want;
        if (!rst_n)
        begin
            token_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (token_valid && token_ready)
            begin
                if (token_expect_q.size() == 0)
                begin
                    $display("%0t: token with none expected, got kind=%0d value=%h last=%b",
                             $time, token_data.token_kind, token_data.token_value,
                             token_data.last_of_run);
                    errors++;
                end
                else
                begin
                    want = token_expect_q.pop_front();
                    if (token_data.token_kind !== want.token_kind
                        || token_data.token_value !== want.token_value
                        || token_data.last_of_run !== want.last_of_run)
                    begin
                        $display("%0t: token mismatch, expected %0d/%h/%b, got %0d/%h/%b",
                                 $time, want.token_kind, want.token_value, want.last_of_run,
                                 token_data.token_kind, token_data.token_value,
                                 token_data.last_of_run);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                token_ready <= 1'b0;
            end
            else
            begin
                token_ready <= 1'b1;
                recv_gap = next_gap(SIDE_RECV);
            end
        end
    end

    initial
    begin : stimulus
        int r;
        int target;
        bit eot;
        logic [20:0] cp;

        // ascii extremes, shortest and largest code points, a surrogate neighbour
        queue_byte(8'h00, 1'b0); queue_byte(8'h7F, 1'b0);
        queue_byte(8'hC2, 1'b0); queue_byte(8'h80, 1'b0);
        queue_byte(8'hF4, 1'b0); queue_byte(8'h8F, 1'b0);
        queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
        queue_byte(8'hED, 1'b0); queue_byte(8'h9F, 1'b0); queue_byte(8'hBF, 1'b0);
        // overlong, surrogate and out-of-range second bytes
        queue_byte(8'hE0, 1'b0); queue_byte(8'h9F, 1'b0);
        queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0);
        queue_byte(8'hF4, 1'b0); queue_byte(8'h90, 1'b0);
        // bad leads
        queue_byte(8'hC1, 1'b0); queue_byte(8'hF5, 1'b0); queue_byte(8'hFF, 1'b0);
        // broken on the last byte, four tokens at once
        queue_byte(8'hF0, 1'b0); queue_byte(8'h90, 1'b0);
        queue_byte(8'h80, 1'b0); queue_byte(8'h41, 1'b0);
        // cut off by end of text
        queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b1);

        target = byte_queue.size() + RANDOM_BYTES;
        while (byte_queue.size() < target)
        begin
            r = $urandom_range(0, 99);
            eot = ($urandom_range(0, 15) == 0);
            if (r < 20)
            begin
                queue_char(21'($urandom_range(0, 21'h7F)), 0, eot);
            end
            else if (r < 40)
            begin
                queue_char(21'($urandom_range(21'h80, 21'h7FF)), 0, eot);
            end
            else if (r < 60)
            begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp ^ 21'h1000;
                queue_char(cp, 0, eot);
            end
            else if (r < 78)
            begin
                queue_char(21'($urandom_range(21'h10000, 21'h10FFFF)), 0, eot);
            end
            else if (r < 86)
            begin
                queue_char(21'($urandom_range(21'h800, 21'h10FFFF)),
                           int'($urandom_range(1, 3)), eot);
            end
            else if (r < 94)
            begin
                queue_byte(8'($urandom_range(8'hC2, 8'hF4)), 1'b0);
                queue_byte(8'($urandom_range(0, 255)), eot);
            end
            else
            begin
                queue_byte(8'($urandom_range(0, 255)), eot);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (byte_queue.size() != 0 || byte_valid)
            @(posedge clk);
        while (token_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && token_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout waiting for tokens");
        $display("== FAIL ==");
        $finish;
    end
endmodule
